// File: design/dlr_pkg.sv
// dlr_pkg: shared types and constants of the dda line rasterizer
// no dependencies; imported by every other design file except dlr_queue
package dlr_pkg;

  localparam int PIX_BITS  = 12;
  localparam int WIN_BITS  = 13;
  localparam int RGBA_BITS = 32;

  localparam logic [WIN_BITS-1:0] WIN_CLAMP      = 13'd4096;
  localparam logic [WIN_BITS-1:0] WIN_WIDTH_RST  = 13'd800;
  localparam logic [WIN_BITS-1:0] WIN_HEIGHT_RST = 13'd600;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [WIN_BITS-1:0] width;
    logic [WIN_BITS-1:0] height;
  } win_t;

endpackage

// File: design/dlr_in_if.sv
// dlr_in_if: input transaction channel (start or step items)
// depends on dlr_pkg
interface dlr_in_if #(
  parameter int COORD_BITS = 16
);
  import dlr_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         op;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic [RGBA_BITS-1:0]         line_rgba;

  modport source(output valid, op, start_x, start_y, end_x, end_y, line_rgba, input ready);
  modport sink(input valid, op, start_x, start_y, end_x, end_y, line_rgba, output ready);
endinterface

// File: design/dlr_out_if.sv
// dlr_out_if: pixel result transaction channel
// depends on dlr_pkg
interface dlr_out_if;
  import dlr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [PIX_BITS-1:0]  pixel_x;
  logic [PIX_BITS-1:0]  pixel_y;
  logic [RGBA_BITS-1:0] pixel_rgba;
  logic                 pixel_valid;
  logic                 line_done;

  modport source(output valid, pixel_x, pixel_y, pixel_rgba, pixel_valid, line_done,
                 input ready);
  modport sink(input valid, pixel_x, pixel_y, pixel_rgba, pixel_valid, line_done,
               output ready);
endinterface

// File: design/dlr_queue.sv
// dlr_queue: small register queue between front and back end
// no package dependency; generic width and depth
module dlr_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          push, pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end
endmodule

// File: design/dlr_front.sv
// dlr_front: accepts input transactions and forms the endpoint deltas
// depends on dlr_pkg and dlr_in_if; feeds dlr_queue
module dlr_front #(
  parameter int COORD_BITS = 16
) (
  dlr_in_if.sink                   in_ch,
  output logic                     push_valid,
  input  logic                     push_ready,
  output logic [4*COORD_BITS+34:0] push_data
);
  import dlr_pkg::*;

  localparam int C = COORD_BITS;

  logic signed [C:0] dx, dy;
  op_t               op;

  assign op = op_t'(in_ch.op);
  assign dx = {in_ch.end_x[C-1], in_ch.end_x} - {in_ch.start_x[C-1], in_ch.start_x};
  assign dy = {in_ch.end_y[C-1], in_ch.end_y} - {in_ch.start_y[C-1], in_ch.start_y};

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;
  assign push_data   = {op == OP_STEP, in_ch.start_x, in_ch.start_y, dx, dy, in_ch.line_rgba};
endmodule

// File: design/dlr_back.sv
// dlr_back: line setup (span, restoring divider) and per-step pixel generation
// depends on dlr_pkg and dlr_out_if; pops from dlr_queue
module dlr_back #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dlr_pkg::win_t            win,
  input  logic                     pop_valid,
  output logic                     pop_ready,
  input  logic [4*COORD_BITS+34:0] pop_data,
  dlr_out_if.source                out_ch
);
  import dlr_pkg::*;

  localparam int C    = COORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int EW   = 4 * C + 35;
  localparam int PW   = C + F + 2;
  localparam int SW   = F + 2;
  localparam int QW   = F + 1;
  localparam int NB   = C + F + 1;
  localparam int NW   = $clog2(NB + 1);
  localparam int XW   = C + 2;
  localparam int CMPW = (XW > WIN_BITS) ? XW : WIN_BITS;
  localparam logic signed [PW-1:0] HALF = {{(PW - F){1'b0}}, 1'b1, {(F - 1){1'b0}}};

  typedef enum logic [5:0] {
    S_READY = 6'b000001,
    S_MAG   = 6'b000010,
    S_SPAN  = 6'b000100,
    S_PREP  = 6'b001000,
    S_DIV   = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  // head of queue
  logic                 op_h;
  logic signed [C-1:0]  x0_h, y0_h;
  logic signed [C:0]    dx_h, dy_h;
  logic [RGBA_BITS-1:0] rgba_h;

  assign op_h   = pop_data[EW-1];
  assign x0_h   = pop_data[EW-2 -: C];
  assign y0_h   = pop_data[EW-2-C -: C];
  assign dx_h   = pop_data[EW-2-2*C -: C+1];
  assign dy_h   = pop_data[EW-3-3*C -: C+1];
  assign rgba_h = pop_data[RGBA_BITS-1:0];

  state_t               state_r, state_nxt;
  logic                 active_r, active_nxt;
  logic                 ov_r, ov_nxt;
  logic signed [PW-1:0] pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic signed [SW-1:0] step_x_r, step_x_nxt, step_y_r, step_y_nxt;
  logic [C-1:0]         left_r, left_nxt;
  logic [RGBA_BITS-1:0] rgba_r, rgba_nxt;
  logic signed [C:0]    dx_r, dx_nxt, dy_r, dy_nxt;
  logic [C-1:0]         mag_x_r, mag_x_nxt, mag_y_r, mag_y_nxt;
  logic [C-1:0]         span_r, span_nxt;
  logic [NB-1:0]        dvd_x_r, dvd_x_nxt, dvd_y_r, dvd_y_nxt;
  logic [C-1:0]         rem_x_r, rem_x_nxt, rem_y_r, rem_y_nxt;
  logic [QW-1:0]        q_x_r, q_x_nxt, q_y_r, q_y_nxt;
  logic [NW-1:0]        cnt_r, cnt_nxt;
  logic [PIX_BITS-1:0]  opx_r, opx_nxt, opy_r, opy_nxt;
  logic [RGBA_BITS-1:0] orgba_r, orgba_nxt;
  logic                 opv_r, opv_nxt, odone_r, odone_nxt;

  logic                 out_free, take;
  logic signed [PW-1:0] sx, sy;
  logic [CMPW-1:0]      xe, ye;
  logic                 in_win;
  logic [C:0]           trial_x, trial_y, span_e;
  logic                 ge_x, ge_y;
  logic [C:0]           neg_dx, neg_dy;
  logic signed [SW-1:0] qx_e, qy_e;

  assign out_free  = !ov_r || out_ch.ready;
  assign pop_ready = (state_r == S_READY) && out_free;
  assign take      = pop_valid && pop_ready;

  // round to nearest, halves away from zero; negative results are clipped anyway
  assign sx     = pos_x_r + HALF;
  assign sy     = pos_y_r + HALF;
  assign xe     = CMPW'(sx[PW-1:F]);
  assign ye     = CMPW'(sy[PW-1:F]);
  assign in_win = !sx[PW-1] && (sx != '0) && !sy[PW-1] && (sy != '0)
                  && (xe < CMPW'(win.width)) && (ye < CMPW'(win.height));

  assign span_e  = {1'b0, span_r};
  assign trial_x = {rem_x_r, dvd_x_r[NB-1]};
  assign trial_y = {rem_y_r, dvd_y_r[NB-1]};
  assign ge_x    = trial_x >= span_e;
  assign ge_y    = trial_y >= span_e;
  assign neg_dx  = -dx_r;
  assign neg_dy  = -dy_r;
  assign qx_e    = SW'(q_x_r);
  assign qy_e    = SW'(q_y_r);

  always_comb begin
    state_nxt  = state_r;
    active_nxt = active_r;
    ov_nxt     = ov_r;
    pos_x_nxt  = pos_x_r;
    pos_y_nxt  = pos_y_r;
    step_x_nxt = step_x_r;
    step_y_nxt = step_y_r;
    left_nxt   = left_r;
    rgba_nxt   = rgba_r;
    dx_nxt     = dx_r;
    dy_nxt     = dy_r;
    mag_x_nxt  = mag_x_r;
    mag_y_nxt  = mag_y_r;
    span_nxt   = span_r;
    dvd_x_nxt  = dvd_x_r;
    dvd_y_nxt  = dvd_y_r;
    rem_x_nxt  = rem_x_r;
    rem_y_nxt  = rem_y_r;
    q_x_nxt    = q_x_r;
    q_y_nxt    = q_y_r;
    cnt_nxt    = cnt_r;
    opx_nxt    = opx_r;
    opy_nxt    = opy_r;
    orgba_nxt  = orgba_r;
    opv_nxt    = opv_r;
    odone_nxt  = odone_r;

    if (take) begin
      ov_nxt  = 1'b1;
      opx_nxt = '0;
      opy_nxt = '0;
      opv_nxt = 1'b0;
      if (op_t'(op_h) == OP_START) begin
        odone_nxt  = 1'b0;
        orgba_nxt  = rgba_h;
        rgba_nxt   = rgba_h;
        pos_x_nxt  = {{2{x0_h[C-1]}}, x0_h, {F{1'b0}}};
        pos_y_nxt  = {{2{y0_h[C-1]}}, y0_h, {F{1'b0}}};
        dx_nxt     = dx_h;
        dy_nxt     = dy_h;
        active_nxt = 1'b1;
        state_nxt  = S_MAG;
      end else if (!active_r) begin
        // idle step
        odone_nxt = 1'b1;
        orgba_nxt = '0;
      end else begin
        opv_nxt   = in_win;
        opx_nxt   = in_win ? xe[PIX_BITS-1:0] : '0;
        opy_nxt   = in_win ? ye[PIX_BITS-1:0] : '0;
        orgba_nxt = rgba_r;
        if (left_r == '0) begin
          odone_nxt  = 1'b1;
          active_nxt = 1'b0;
        end else begin
          odone_nxt = 1'b0;
          pos_x_nxt = pos_x_r + PW'(step_x_r);
          pos_y_nxt = pos_y_r + PW'(step_y_r);
          left_nxt  = left_r - 1'b1;
        end
      end
    end else if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      S_READY: begin
      end
      S_MAG: begin
        mag_x_nxt = dx_r[C] ? neg_dx[C-1:0] : dx_r[C-1:0];
        mag_y_nxt = dy_r[C] ? neg_dy[C-1:0] : dy_r[C-1:0];
        state_nxt = S_SPAN;
      end
      S_SPAN: begin
        span_nxt  = (mag_x_r >= mag_y_r) ? mag_x_r : mag_y_r;
        state_nxt = S_PREP;
      end
      S_PREP: begin
        left_nxt  = span_r;
        dvd_x_nxt = {1'b0, mag_x_r, {F{1'b0}}} + NB'(span_r >> 1);
        dvd_y_nxt = {1'b0, mag_y_r, {F{1'b0}}} + NB'(span_r >> 1);
        rem_x_nxt = '0;
        rem_y_nxt = '0;
        q_x_nxt   = '0;
        q_y_nxt   = '0;
        cnt_nxt   = NW'(NB);
        if (span_r == '0) begin
          step_x_nxt = '0;
          step_y_nxt = '0;
          state_nxt  = S_READY;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // restoring division, one quotient bit per cycle
        rem_x_nxt = ge_x ? C'(trial_x - span_e) : trial_x[C-1:0];
        rem_y_nxt = ge_y ? C'(trial_y - span_e) : trial_y[C-1:0];
        q_x_nxt   = {q_x_r[QW-2:0], ge_x};
        q_y_nxt   = {q_y_r[QW-2:0], ge_y};
        dvd_x_nxt = {dvd_x_r[NB-2:0], 1'b0};
        dvd_y_nxt = {dvd_y_r[NB-2:0], 1'b0};
        cnt_nxt   = cnt_r - 1'b1;
        if (cnt_r == NW'(1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        step_x_nxt = dx_r[C] ? -qx_e : qx_e;
        step_y_nxt = dy_r[C] ? -qy_e : qy_e;
        state_nxt  = S_READY;
      end
      default: begin
        state_nxt = S_READY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_READY;
      active_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      active_r <= active_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_x_r  <= pos_x_nxt;
    pos_y_r  <= pos_y_nxt;
    step_x_r <= step_x_nxt;
    step_y_r <= step_y_nxt;
    left_r   <= left_nxt;
    rgba_r   <= rgba_nxt;
    dx_r     <= dx_nxt;
    dy_r     <= dy_nxt;
    mag_x_r  <= mag_x_nxt;
    mag_y_r  <= mag_y_nxt;
    span_r   <= span_nxt;
    dvd_x_r  <= dvd_x_nxt;
    dvd_y_r  <= dvd_y_nxt;
    rem_x_r  <= rem_x_nxt;
    rem_y_r  <= rem_y_nxt;
    q_x_r    <= q_x_nxt;
    q_y_r    <= q_y_nxt;
    cnt_r    <= cnt_nxt;
    opx_r    <= opx_nxt;
    opy_r    <= opy_nxt;
    orgba_r  <= orgba_nxt;
    opv_r    <= opv_nxt;
    odone_r  <= odone_nxt;
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.pixel_x     = opx_r;
  assign out_ch.pixel_y     = opy_r;
  assign out_ch.pixel_rgba  = orgba_r;
  assign out_ch.pixel_valid = opv_r;
  assign out_ch.line_done   = odone_r;
endmodule

// File: design/dda_line_rasterizer.sv
// dda_line_rasterizer: top level, window registers, front end, queue, back end
// depends on dlr_pkg, dlr_in_if, dlr_out_if, dlr_front, dlr_queue, dlr_back
//
//  channel | direction | handshake        | payload
//  in_ch   | sink      | valid / ready    | op, start_x, start_y, end_x, end_y, line_rgba
//  out_ch  | source    | valid / ready    | pixel_x, pixel_y, pixel_rgba, pixel_valid, line_done
//  cfg_    | write     | cfg_we           | cfg_index, cfg_data
//
// step transactions: one pixel per cycle through the output register while out_ch is not stalled
// start transactions: the back end walks S_MAG, S_SPAN, S_PREP, S_DIV (the restoring divider,
//   one quotient bit per cycle) and S_FIN (both skipped for a zero span); no new item until S_READY
// a two-entry queue keeps the input side taking transactions while the back end works
// reset (synchronous, rst_n low) empties the queue, drops any line, sets window 800 x 600
module dda_line_rasterizer #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  dlr_in_if.sink                        in_ch,
  dlr_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [dlr_pkg::WIN_BITS-1:0]  cfg_data
);
  import dlr_pkg::*;

  localparam int EW = 4 * COORD_BITS + 35;

  win_t          win_r;
  logic          push_valid, push_ready, pop_valid, pop_ready;
  logic [EW-1:0] push_data, pop_data;
  logic [WIN_BITS-1:0] cfg_clamped;

  // anything past 4096 behaves as 4096
  assign cfg_clamped = (cfg_data > WIN_CLAMP) ? WIN_CLAMP : cfg_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r.width  <= WIN_WIDTH_RST;
      win_r.height <= WIN_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WIDTH:  win_r.width  <= cfg_clamped;
        CFG_HEIGHT: win_r.height <= cfg_clamped;
      endcase
    end
  end

  dlr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  dlr_queue #(
    .W     (EW),
    .DEPTH (2)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  dlr_back #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .win       (win_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );
endmodule

// File: design/dlr_checker.sv
// dlr_checker: port-level checks on the result channel of the rasterizer
// depends on dlr_pkg; bound to dda_line_rasterizer below
module dlr_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [dlr_pkg::PIX_BITS-1:0]   pixel_x,
  input logic [dlr_pkg::PIX_BITS-1:0]   pixel_y,
  input logic [dlr_pkg::RGBA_BITS-1:0]  pixel_rgba,
  input logic                           pixel_valid,
  input logic                           line_done
);
  import dlr_pkg::*;

  // stalled transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
      && $stable(pixel_rgba) && $stable(pixel_valid) && $stable(line_done))
    else $error("result changed while stalled");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // clipped or non-pixel results carry zero coordinates
  a_clip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !pixel_valid |-> pixel_x == '0 && pixel_y == '0)
    else $error("nonzero coordinates on invalid pixel");

  // an offered transaction carries no unknown bits
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown({pixel_x, pixel_y, pixel_rgba, pixel_valid, line_done}))
    else $error("unknown bits on offered result");
endmodule

bind dda_line_rasterizer dlr_checker u_dlr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .pixel_x     (out_ch.pixel_x),
  .pixel_y     (out_ch.pixel_y),
  .pixel_rgba  (out_ch.pixel_rgba),
  .pixel_valid (out_ch.pixel_valid),
  .line_done   (out_ch.line_done)
);

// File: dv/tb_dda_line_rasterizer.sv
`timescale 1ns / 1ps
// tb_dda_line_rasterizer: self-checking testbench for the dda line rasterizer
// a scoreboard class predicts every pixel transaction; plain tasks drive the input and config ports
// depends on dlr_pkg, dlr_in_if, dlr_out_if and dda_line_rasterizer
module tb_dda_line_rasterizer;
  import dlr_pkg::*;

  localparam int COORD = 16;
  localparam int FRAC  = 16;
  localparam int PHASES = 8;

  typedef struct {
    op_t                     op;
    logic signed [COORD-1:0] sx;
    logic signed [COORD-1:0] sy;
    logic signed [COORD-1:0] ex;
    logic signed [COORD-1:0] ey;
    logic [RGBA_BITS-1:0]    rgba;
  } line_cmd_t;

  typedef struct {
    logic [PIX_BITS-1:0]  x;
    logic [PIX_BITS-1:0]  y;
    logic [RGBA_BITS-1:0] rgba;
    logic                 vis;
    logic                 done;
  } pixel_t;

  class pixel_scoreboard;
    logic [WIN_BITS-1:0]  win_w;
    logic [WIN_BITS-1:0]  win_h;
    bit                   active;
    longint               pos_x;
    longint               pos_y;
    longint               inc_x;
    longint               inc_y;
    longint               remaining;
    logic [RGBA_BITS-1:0] color;
    pixel_t               expected_pixels[$];
    int                   mismatches;
    int                   checked;

    function new();
      win_w = WIN_WIDTH_RST;
      win_h = WIN_HEIGHT_RST;
      active = 1'b0;
      pos_x = 0;
      pos_y = 0;
      inc_x = 0;
      inc_y = 0;
      remaining = 0;
      color = '0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void set_window(logic [WIN_BITS-1:0] w, logic [WIN_BITS-1:0] h);
      win_w = w;
      win_h = h;
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    // per-step increment, nearest with halves away from zero
    function longint axis_inc(longint d, longint span);
      longint q;
      if (span == 0) return 0;
      q = (((d < 0) ? -d : d) * (longint'(1) << FRAC) + span / 2) / span;
      return (d < 0) ? -q : q;
    endfunction

    function longint to_pixel(longint p);
      longint r;
      r = (((p < 0) ? -p : p) + (longint'(1) << (FRAC - 1))) / (longint'(1) << FRAC);
      return (p < 0) ? -r : r;
    endfunction

    function void note_item(line_cmd_t c);
      pixel_t px;
      longint dx;
      longint dy;
      longint span;
      longint x;
      longint y;
      longint w;
      longint h;
      px = '{default: '0};
      if (c.op == OP_START) begin
        dx = longint'(c.ex) - longint'(c.sx);
        dy = longint'(c.ey) - longint'(c.sy);
        span = (dx < 0) ? -dx : dx;
        if (((dy < 0) ? -dy : dy) > span) span = (dy < 0) ? -dy : dy;
        color = c.rgba;
        pos_x = longint'(c.sx) * (longint'(1) << FRAC);
        pos_y = longint'(c.sy) * (longint'(1) << FRAC);
        inc_x = axis_inc(dx, span);
        inc_y = axis_inc(dy, span);
        remaining = span;
        active = 1'b1;
        px.rgba = color;
      end else if (!active) begin
        px.done = 1'b1;
      end else begin
        x = to_pixel(pos_x);
        y = to_pixel(pos_y);
        w = (win_w > WIN_CLAMP) ? longint'(WIN_CLAMP) : longint'(win_w);
        h = (win_h > WIN_CLAMP) ? longint'(WIN_CLAMP) : longint'(win_h);
        if (x >= 0 && x < w && y >= 0 && y < h) begin
          px.x = x[PIX_BITS-1:0];
          px.y = y[PIX_BITS-1:0];
          px.vis = 1'b1;
        end
        px.rgba = color;
        if (remaining == 0) begin
          px.done = 1'b1;
          active = 1'b0;
        end else begin
          pos_x += inc_x;
          pos_y += inc_y;
          remaining--;
        end
      end
      expected_pixels.push_back(px);
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pixel transaction: x=%0d y=%0d rgba=%h valid=%b done=%b",
                   got.x, got.y, got.rgba, got.vis, got.done);
        return;
      end
      want = expected_pixels.pop_front();
      checked++;
      if (got.x !== want.x || got.y !== want.y || got.rgba !== want.rgba ||
          got.vis !== want.vis || got.done !== want.done) begin
        mismatches++;
        if (mismatches <= 10)
          $display("pixel %0d mismatch: expected x=%0d y=%0d rgba=%h valid=%b done=%b,",
                   checked, want.x, want.y, want.rgba, want.vis, want.done,
                   " got x=%0d y=%0d rgba=%h valid=%b done=%b",
                   got.x, got.y, got.rgba, got.vis, got.done);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic                cfg_index;
  logic [WIN_BITS-1:0] cfg_data;

  dlr_in_if #(.COORD_BITS(COORD)) in_ch ();
  dlr_out_if out_ch ();

  dda_line_rasterizer #(
    .COORD_BITS(COORD),
    .FRAC_BITS (FRAC)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  pixel_scoreboard sb;
  int sent;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic send_cmd(line_cmd_t c);
    int gap;
    gap = (sent % 50 < 12) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.op        <= c.op;
    in_ch.start_x   <= c.sx;
    in_ch.start_y   <= c.sy;
    in_ch.end_x     <= c.ex;
    in_ch.end_y     <= c.ey;
    in_ch.line_rgba <= c.rgba;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_item(c);
    sent++;
  endtask

  task automatic start_line(int sx, int sy, int ex, int ey, logic [RGBA_BITS-1:0] rgba);
    line_cmd_t c;
    c.op = OP_START;
    c.sx = sx[COORD-1:0];
    c.sy = sy[COORD-1:0];
    c.ex = ex[COORD-1:0];
    c.ey = ey[COORD-1:0];
    c.rgba = rgba;
    send_cmd(c);
  endtask

  // step payload is ignored by the block, so it carries random bits
  task automatic send_raw(op_t op, int n);
    line_cmd_t c;
    repeat (n) begin
      c.op = op;
      c.sx = COORD'($urandom());
      c.sy = COORD'($urandom());
      c.ex = COORD'($urandom());
      c.ey = COORD'($urandom());
      c.rgba = $urandom();
      send_cmd(c);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic set_window(logic [WIN_BITS-1:0] w, logic [WIN_BITS-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= CFG_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_window(w, h);
  endtask

  task automatic random_line(int weff, int heff);
    int kind;
    int lim;
    int cx;
    int cy;
    int dx;
    int dy;
    int span;
    int n;
    int r;
    kind = $urandom_range(0, 9);
    if (kind <= 5 || kind == 7) begin
      if (kind == 7) begin
        cx = 4088 + $urandom_range(0, 12);
        cy = 4088 + $urandom_range(0, 12);
        lim = 8;
      end else begin
        cx = int'($urandom_range(0, weff + 16)) - 8;
        cy = int'($urandom_range(0, heff + 16)) - 8;
        lim = ($urandom_range(0, 9) == 0) ? 200 : 12;
      end
      dx = int'($urandom_range(0, 2 * lim)) - lim;
      dy = int'($urandom_range(0, 2 * lim)) - lim;
      start_line(cx, cy, cx + dx, cy + dy, $urandom());
      span = (dx < 0) ? -dx : dx;
      if (((dy < 0) ? -dy : dy) > span) span = (dy < 0) ? -dy : dy;
      n = span + 1;
      r = $urandom_range(0, 5);
      if (r == 0) n += $urandom_range(1, 3);
      else if (r == 1) n = $urandom_range(0, span);
      send_raw(OP_STEP, n);
    end else if (kind == 6) begin
      start_line($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      send_raw(OP_STEP, $urandom_range(1, 6));
    end else if (kind == 8) begin
      repeat ($urandom_range(1, 3)) send_raw(op_t'($urandom_range(0, 1)), 1);
    end else begin
      send_raw(OP_STEP, 1);
    end
  endtask

  initial begin
    logic [WIN_BITS-1:0] w_list [PHASES];
    logic [WIN_BITS-1:0] h_list [PHASES];
    int weff;
    int heff;
    int target;
    int failed;
    sb = new();
    sent = 0;
    w_list = '{13'd1, 13'd4096, 13'd8191, 13'd0, 13'd4095, 13'd4097, 13'd0, 13'd0};
    h_list = '{13'd1, 13'd4096, 13'd0, 13'd8191, 13'd4097, 13'd2, 13'd0, 13'd0};
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_WIDTH;
    cfg_data        <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.op        <= OP_STEP;
    in_ch.start_x   <= '0;
    in_ch.start_y   <= '0;
    in_ch.end_x     <= '0;
    in_ch.end_y     <= '0;
    in_ch.line_rgba <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed lines at the reset window
    send_raw(OP_STEP, 1);
    start_line(0, 0, 0, 0, 32'hFFFF_FFFF);
    send_raw(OP_STEP, 2);
    start_line(-32768, -32768, 32767, 32767, 32'h0000_0000);
    send_raw(OP_STEP, 2);
    start_line(32767, -32768, -32768, 32767, 32'h5A5A_5A5A);
    send_raw(OP_STEP, 1);
    start_line(799, 599, 801, 597, 32'hA5C3_0F96);
    send_raw(OP_STEP, 3);
    start_line(3, 3, 1, 2, 32'h1234_5678);
    send_raw(OP_STEP, 3);
    start_line(5, 0, 6, 9, 32'h8000_0001);
    send_raw(OP_STEP, 3);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      if (p >= 6) begin
        w_list[p] = WIN_BITS'($urandom_range(0, 8191));
        h_list[p] = WIN_BITS'($urandom_range(0, 8191));
      end
      set_window(w_list[p], h_list[p]);
      weff = (w_list[p] > WIN_CLAMP) ? int'(WIN_CLAMP) : int'(w_list[p]);
      heff = (h_list[p] > WIN_CLAMP) ? int'(WIN_CLAMP) : int'(h_list[p]);
      target = sent + 100;
      while (sent < target) random_line(weff, heff);
      drain();
    end

    for (int i = 0; i < 5000 && sb.pending() != 0; i++) @(posedge clk);
    repeat (60) @(posedge clk);
    failed = sb.mismatches + sb.pending();
    $display("run covered %0d input transactions and %0d checked pixels over %0d windows",
             sent, sb.checked, PHASES + 1);
    if (failed == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    int stall;
    int got;
    pixel_t px;
    got = 0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      stall = (got % 64 < 16) ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      px.x    = out_ch.pixel_x;
      px.y    = out_ch.pixel_y;
      px.rgba = out_ch.pixel_rgba;
      px.vis  = out_ch.pixel_valid;
      px.done = out_ch.line_done;
      sb.check_pixel(px);
      got++;
    end
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
